[sv/pipeline_hazard_forward_unit_defines.svh]
// ----------------------------------------------------------------------------
// pipeline hazard forward unit assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef PIPELINE_HAZARD_FORWARD_UNIT_DEFINES_SVH
`define PIPELINE_HAZARD_FORWARD_UNIT_DEFINES_SVH

// antecedent sequence, then consequent in the cycle after its end
`define HFU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hazard forward unit check failed");

// state right after a reset cycle
`define HFU_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("hazard forward unit reset check failed");

`endif

[sv/hfu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfu_pkg
// shared types and constants of the pipeline hazard forward unit
// ----------------------------------------------------------------------------
package hfu_pkg;

   localparam int unsigned ADDR_BITS_DEF = 5;

   localparam int unsigned STALL_W = 7;
   localparam int unsigned FLUSH_W = 6;

   // forwarding mux codes
   localparam logic [1:0] SEL_RF   = 2'd0;
   localparam logic [1:0] SEL_MEM  = 2'd1;
   localparam logic [1:0] SEL_WB   = 2'd2;
   localparam logic [1:0] SEL_NEAR = 2'd3;

   // middle tier codes
   localparam logic [1:0] MID_NONE = 2'd0;
   localparam logic [1:0] MID_EX1B = 2'd1;
   localparam logic [1:0] MID_EX2  = 2'd2;

   // control input bit positions
   localparam int unsigned ISTALL_BIT = 0;
   localparam int unsigned DSTALL_BIT = 1;
   localparam int unsigned JAL_BIT    = 0;
   localparam int unsigned EXR_BIT    = 1;
   localparam int unsigned TRAP_BIT   = 2;

   // stall and flush patterns
   localparam logic [STALL_W-1:0] STALL_NONE  = 7'h00;
   localparam logic [STALL_W-1:0] STALL_ALL   = 7'h7F;
   localparam logic [STALL_W-1:0] STALL_LU    = 7'h03;
   localparam logic [STALL_W-1:0] STALL_FETCH = 7'h01;
   localparam logic [FLUSH_W-1:0] FLUSH_NONE  = 6'h00;
   localparam logic [FLUSH_W-1:0] FLUSH_ALL   = 6'h3F;
   localparam logic [FLUSH_W-1:0] FLUSH_IFID  = 6'h01;
   localparam logic [FLUSH_W-1:0] FLUSH_IDEX  = 6'h02;

   // result word layout
   localparam int unsigned RSP_RAW       = STALL_W + FLUSH_W + 20;
   localparam int unsigned RSP_W         = ((RSP_RAW + 7) / 8) * 8;
   localparam int unsigned RSP_STALL_LSB = 0;
   localparam int unsigned RSP_FLUSH_LSB = STALL_W;
   localparam int unsigned RSP_A_SEL_LSB = STALL_W + FLUSH_W;
   localparam int unsigned RSP_A_MID_LSB = STALL_W + FLUSH_W + 6;

   typedef struct packed {
      logic [1:0] sel;
      logic [1:0] mid;
   } fwd_type;

   typedef struct packed {
      logic [STALL_W-1:0] stall;
      logic [FLUSH_W-1:0] flush;
   } ctrl_type;

endpackage

[sv/hfu_cascade.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfu_cascade
// priority forwarding cascade over five producer tiers for one operand
// ----------------------------------------------------------------------------
module hfu_cascade #(
   parameter int unsigned ADDR_BITS = hfu_pkg::ADDR_BITS_DEF
) (
   input  logic [ADDR_BITS-1:0] src,
   input  logic [ADDR_BITS+1:0] tier1,
   input  logic [ADDR_BITS+1:0] tier2,
   input  logic [ADDR_BITS+1:0] tier3,
   input  logic [ADDR_BITS+1:0] tier4,
   input  logic [ADDR_BITS:0]   tier5,
   output hfu_pkg::fwd_type     res
);

   function automatic logic hit(input logic [ADDR_BITS:0] p, input logic [ADDR_BITS-1:0] s);
      logic [ADDR_BITS-1:0] rd;
      begin
         rd  = p[ADDR_BITS-1:0];
         hit = p[ADDR_BITS] && (rd != '0) && (rd == s);
      end
   endfunction

   logic       hit1, hit2, hit3, hit4, hit5;
   logic [1:0] sel_code, mid_code;

   assign hit1 = hit(tier1[ADDR_BITS:0], src);
   assign hit2 = hit(tier2[ADDR_BITS:0], src);
   assign hit3 = hit(tier3[ADDR_BITS:0], src);
   // a load in the fourth tier has no data yet
   assign hit4 = hit(tier4[ADDR_BITS:0], src) && !tier4[ADDR_BITS+1];
   assign hit5 = hit(tier5, src);

   assign sel_code = hit1            ? hfu_pkg::SEL_NEAR :
                     (hit2 || hit3)  ? hfu_pkg::SEL_RF   :
                     hit4            ? hfu_pkg::SEL_MEM  :
                     hit5            ? hfu_pkg::SEL_WB   : hfu_pkg::SEL_RF;

   assign mid_code = hit1 ? hfu_pkg::MID_NONE :
                     hit2 ? hfu_pkg::MID_EX1B :
                     hit3 ? hfu_pkg::MID_EX2  : hfu_pkg::MID_NONE;

   assign res = '{sel: sel_code, mid: mid_code};

endmodule

[sv/hfu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfu_ctrl
// load-use detection and stall / flush priority chain
// ----------------------------------------------------------------------------
module hfu_ctrl #(
   parameter int unsigned ADDR_BITS = hfu_pkg::ADDR_BITS_DEF
) (
   input  logic [ADDR_BITS-1:0] id_src1,
   input  logic [ADDR_BITS-1:0] id_src2,
   input  logic [ADDR_BITS+1:0] prod_ex1a,
   input  logic [ADDR_BITS+1:0] prod_ex1c,
   input  logic [ADDR_BITS+1:0] prod_ex1b,
   input  logic [ADDR_BITS+1:0] prod_ex2,
   input  logic [1:0]           cache_stalls,
   input  logic [2:0]           redirects,
   output hfu_pkg::ctrl_type    ctrl
);

   function automatic logic ld_use(input logic [ADDR_BITS+1:0] p,
                                   input logic [ADDR_BITS-1:0] s1,
                                   input logic [ADDR_BITS-1:0] s2);
      logic [ADDR_BITS-1:0] rd;
      begin
         rd     = p[ADDR_BITS-1:0];
         ld_use = p[ADDR_BITS+1] && (rd != '0) && ((rd == s1) || (rd == s2));
      end
   endfunction

   logic                        ld_hazard;
   logic                        trap, dstall, exr, jal, istall;
   logic [hfu_pkg::STALL_W-1:0] stall_code;
   logic [hfu_pkg::FLUSH_W-1:0] flush_code;

   assign ld_hazard = ld_use(prod_ex1a, id_src1, id_src2) ||
                      ld_use(prod_ex1c, id_src1, id_src2) ||
                      ld_use(prod_ex1b, id_src1, id_src2) ||
                      ld_use(prod_ex2,  id_src1, id_src2);

   assign trap   = redirects[hfu_pkg::TRAP_BIT];
   assign dstall = cache_stalls[hfu_pkg::DSTALL_BIT];
   assign exr    = redirects[hfu_pkg::EXR_BIT];
   assign jal    = redirects[hfu_pkg::JAL_BIT];
   assign istall = cache_stalls[hfu_pkg::ISTALL_BIT];

   // trap > dcache stall > ex redirect > jal > load-use > icache stall
   assign stall_code = trap         ? hfu_pkg::STALL_NONE  :
                       dstall       ? hfu_pkg::STALL_ALL   :
                       (exr || jal) ? hfu_pkg::STALL_NONE  :
                       ld_hazard    ? hfu_pkg::STALL_LU    :
                       istall       ? hfu_pkg::STALL_FETCH : hfu_pkg::STALL_NONE;

   assign flush_code = trap         ? hfu_pkg::FLUSH_ALL  :
                       dstall       ? hfu_pkg::FLUSH_NONE :
                       exr          ? hfu_pkg::FLUSH_ALL  :
                       jal          ? hfu_pkg::FLUSH_IFID :
                       ld_hazard    ? hfu_pkg::FLUSH_IDEX : hfu_pkg::FLUSH_NONE;

   assign ctrl = '{stall: stall_code, flush: flush_code};

endmodule

[sv/pipeline_hazard_forward_unit.sv]
`timescale 1ns / 1ps
// rsp_tvalid rises once the accepted req word has passed the input register and then the result register
// throughput: one word per cycle while rsp_tready is high; an empty input register refills while the result waits
// the single pass of cascade and priority logic between the two registers sets the rate
// reset clears both valid flags; the data registers are not reset, and no other state is kept
// ----------------------------------------------------------------------------
// pipeline_hazard_forward_unit
// forwarding selects and stall / flush vectors for the pipeline
// ----------------------------------------------------------------------------
module pipeline_hazard_forward_unit #(
   parameter  int unsigned ADDR_BITS = hfu_pkg::ADDR_BITS_DEF,
   localparam int unsigned REQ_RAW   = 10 * ADDR_BITS + 16,
   localparam int unsigned REQ_W     = ((REQ_RAW + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // ex_src1, ex_src2, id_src1, id_src2, prod_ex1a, prod_ex1c, prod_ex1b,
   // prod_ex2, prod_mem, prod_wb, cache_stalls, redirects
   input  logic [REQ_W-1:0]          req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // stall_bits, flush_bits, fwd_a_select, fwd_b_select, fwd_st_select,
   // fwd_a_middle, fwd_b_middle, fwd_st_middle, pre_a_select, pre_a_middle,
   // pre_b_select, pre_b_middle
   output logic [hfu_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int unsigned PW      = ADDR_BITS + 2;
   localparam int unsigned OFS_ES1 = 0;
   localparam int unsigned OFS_ES2 = ADDR_BITS;
   localparam int unsigned OFS_IS1 = 2 * ADDR_BITS;
   localparam int unsigned OFS_IS2 = 3 * ADDR_BITS;
   localparam int unsigned OFS_P1A = 4 * ADDR_BITS;
   localparam int unsigned OFS_P1C = OFS_P1A + PW;
   localparam int unsigned OFS_P1B = OFS_P1A + 2 * PW;
   localparam int unsigned OFS_P2  = OFS_P1A + 3 * PW;
   localparam int unsigned OFS_PM  = OFS_P1A + 4 * PW;
   localparam int unsigned OFS_PWB = OFS_P1A + 5 * PW;
   localparam int unsigned OFS_CS  = OFS_PWB + ADDR_BITS + 1;
   localparam int unsigned OFS_RD  = OFS_CS + 2;
   localparam int unsigned PAD_W   = hfu_pkg::RSP_W - hfu_pkg::RSP_RAW;

   logic                     in_vld_ff, in_vld_in;
   logic                     out_vld_ff, out_vld_in;
   logic [REQ_RAW-1:0]       req_data_ff;
   logic [hfu_pkg::RSP_RAW-1:0] rsp_data_ff, rsp_data_in;
   logic                     req_take, advance;

   logic [ADDR_BITS-1:0]     ex_src1, ex_src2, id_src1, id_src2;
   logic [ADDR_BITS+1:0]     prod_ex1a, prod_ex1c, prod_ex1b, prod_ex2, prod_mem;
   logic [ADDR_BITS:0]       prod_wb;
   logic [1:0]               cache_stalls;
   logic [2:0]               redirects;

   hfu_pkg::fwd_type         fwd_a, fwd_b, pre_a, pre_b;
   hfu_pkg::ctrl_type        ctrl;

   // result register loads from a valid input register whenever it is empty or being drained
   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance ? in_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff <= req_tdata[REQ_RAW-1:0];
      end
      if (advance && in_vld_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign ex_src1      = req_data_ff[OFS_ES1 +: ADDR_BITS];
   assign ex_src2      = req_data_ff[OFS_ES2 +: ADDR_BITS];
   assign id_src1      = req_data_ff[OFS_IS1 +: ADDR_BITS];
   assign id_src2      = req_data_ff[OFS_IS2 +: ADDR_BITS];
   assign prod_ex1a    = req_data_ff[OFS_P1A +: PW];
   assign prod_ex1c    = req_data_ff[OFS_P1C +: PW];
   assign prod_ex1b    = req_data_ff[OFS_P1B +: PW];
   assign prod_ex2     = req_data_ff[OFS_P2 +: PW];
   assign prod_mem     = req_data_ff[OFS_PM +: PW];
   assign prod_wb      = req_data_ff[OFS_PWB +: ADDR_BITS + 1];
   assign cache_stalls = req_data_ff[OFS_CS +: 2];
   assign redirects    = req_data_ff[OFS_RD +: 3];

   hfu_cascade #(.ADDR_BITS(ADDR_BITS)) u_fwd_a (
      .src   (ex_src1),
      .tier1 (prod_ex1c),
      .tier2 (prod_ex1b),
      .tier3 (prod_ex2),
      .tier4 (prod_mem),
      .tier5 (prod_wb),
      .res   (fwd_a)
   );

   hfu_cascade #(.ADDR_BITS(ADDR_BITS)) u_fwd_b (
      .src   (ex_src2),
      .tier1 (prod_ex1c),
      .tier2 (prod_ex1b),
      .tier3 (prod_ex2),
      .tier4 (prod_mem),
      .tier5 (prod_wb),
      .res   (fwd_b)
   );

   // id stage view: every producer one stage younger, mem in the wb tier
   hfu_cascade #(.ADDR_BITS(ADDR_BITS)) u_pre_a (
      .src   (id_src1),
      .tier1 (prod_ex1a),
      .tier2 (prod_ex1c),
      .tier3 (prod_ex1b),
      .tier4 (prod_ex2),
      .tier5 (prod_mem[ADDR_BITS:0]),
      .res   (pre_a)
   );

   hfu_cascade #(.ADDR_BITS(ADDR_BITS)) u_pre_b (
      .src   (id_src2),
      .tier1 (prod_ex1a),
      .tier2 (prod_ex1c),
      .tier3 (prod_ex1b),
      .tier4 (prod_ex2),
      .tier5 (prod_mem[ADDR_BITS:0]),
      .res   (pre_b)
   );

   hfu_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
      .id_src1      (id_src1),
      .id_src2      (id_src2),
      .prod_ex1a    (prod_ex1a),
      .prod_ex1c    (prod_ex1c),
      .prod_ex1b    (prod_ex1b),
      .prod_ex2     (prod_ex2),
      .cache_stalls (cache_stalls),
      .redirects    (redirects),
      .ctrl         (ctrl)
   );

   // store data path follows operand b
   assign rsp_data_in = {pre_b.mid, pre_b.sel, pre_a.mid, pre_a.sel,
                         fwd_b.mid, fwd_b.mid, fwd_a.mid,
                         fwd_b.sel, fwd_b.sel, fwd_a.sel,
                         ctrl.flush, ctrl.stall};

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_data_ff};

endmodule

[sv/hfu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfu_checker
// port-level checks of the pipeline hazard forward unit, bound to the top
// ----------------------------------------------------------------------------
`include "pipeline_hazard_forward_unit_defines.svh"

module hfu_checker #(
   parameter  int unsigned ADDR_BITS = hfu_pkg::ADDR_BITS_DEF,
   localparam int unsigned REQ_RAW   = 10 * ADDR_BITS + 16,
   localparam int unsigned REQ_W     = ((REQ_RAW + 7) / 8) * 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_W-1:0]          req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [hfu_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int unsigned PW      = ADDR_BITS + 2;
   localparam int unsigned OFS_P1C = 4 * ADDR_BITS + PW;
   localparam int unsigned OFS_CS  = 4 * ADDR_BITS + 5 * PW + ADDR_BITS + 1;
   localparam int unsigned OFS_RD  = OFS_CS + 2;

   logic                      req_take;
   logic [ADDR_BITS-1:0]      c_ex_src1;
   logic [ADDR_BITS+1:0]      c_ex1c;
   logic                      c_trap, c_dstall, c_near_a;
   logic [hfu_pkg::STALL_W-1:0] c_stall;
   logic [hfu_pkg::FLUSH_W-1:0] c_flush;
   logic [1:0]                c_a_sel, c_a_mid;

   assign req_take  = req_tvalid && req_tready;
   assign c_ex_src1 = req_tdata[ADDR_BITS-1:0];
   assign c_ex1c    = req_tdata[OFS_P1C +: PW];
   assign c_trap    = req_tdata[OFS_RD + hfu_pkg::TRAP_BIT];
   assign c_dstall  = req_tdata[OFS_CS + hfu_pkg::DSTALL_BIT];
   assign c_near_a  = c_ex1c[ADDR_BITS] && (c_ex1c[ADDR_BITS-1:0] != '0) &&
                      (c_ex1c[ADDR_BITS-1:0] == c_ex_src1);
   assign c_stall   = rsp_tdata[hfu_pkg::RSP_STALL_LSB +: hfu_pkg::STALL_W];
   assign c_flush   = rsp_tdata[hfu_pkg::RSP_FLUSH_LSB +: hfu_pkg::FLUSH_W];
   assign c_a_sel   = rsp_tdata[hfu_pkg::RSP_A_SEL_LSB +: 2];
   assign c_a_mid   = rsp_tdata[hfu_pkg::RSP_A_MID_LSB +: 2];

   // a stalled result word holds
   `HFU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a trap word reaches the output through the input and result registers when drained
   `HFU_ASSERT_NEXT(a_trap_flush, clock, reset, (req_take && c_trap) ##1 rsp_tready, rsp_tvalid && (c_flush == hfu_pkg::FLUSH_ALL) && (c_stall == hfu_pkg::STALL_NONE))

   // data cache stall without a trap freezes every stage
   `HFU_ASSERT_NEXT(a_dstall, clock, reset, (req_take && !c_trap && c_dstall) ##1 rsp_tready, rsp_tvalid && (c_stall == hfu_pkg::STALL_ALL) && (c_flush == hfu_pkg::FLUSH_NONE))

   // nearest producer always wins operand a
   `HFU_ASSERT_NEXT(a_near_fwd, clock, reset, (req_take && c_near_a) ##1 rsp_tready, rsp_tvalid && (c_a_sel == hfu_pkg::SEL_NEAR) && (c_a_mid == hfu_pkg::MID_NONE))

   `HFU_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind pipeline_hazard_forward_unit hfu_checker #(.ADDR_BITS(ADDR_BITS)) u_hfu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
